@@ src/lpcd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpcd_pkg
// Shared types, sizes and codes of the LRU page cache directory.
// ----------------------------------------------------------------------------
package lpcd_pkg;

  // Sizing of the directory.
  localparam int SLOT_COUNT       = 8;
  localparam int PAGE_NUMBER_BITS = 32;

  // Field widths of the request and the response.
  localparam int FUNC_W     = 2;
  localparam int PAGE_IN_W  = 32;
  localparam int LEN_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int SLOT_NUM_W = 3;
  localparam int OFFSET_W   = 19;

  // Derived sizes. Page numbers never carry more than the 32 request bits.
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RANK_W = SLOT_W;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int TAG_W  = (PAGE_NUMBER_BITS < PAGE_IN_W) ? PAGE_NUMBER_BITS : PAGE_IN_W;
  localparam int PROD_W = SLOT_W + LEN_W;

  localparam logic [LEN_W-1:0] PAGE_BYTES_RESET = LEN_W'(4096);

  // Operation codes of a request.
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // Status codes of a response.
  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FILLED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EVICTED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [PAGE_IN_W-1:0] page_number;
    logic [LEN_W-1:0]     page_length;
  } lpcd_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic [OFFSET_W-1:0]   byte_offset;
  } lpcd_rsp_t;

  // Slot table update chosen by the controller.
  typedef enum logic [2:0] {
    UPD_NONE  = 3'd0,
    UPD_TOUCH = 3'd1,
    UPD_FILL  = 3'd2,
    UPD_EVICT = 3'd3,
    UPD_CLEAR = 3'd4
  } upd_op_t;

  typedef struct packed {
    logic                load_req;
    logic                load_result;
    logic                load_offset;
    upd_op_t             op;
    logic [STATUS_W-1:0] status;
  } lpcd_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              hit;
    logic              free;
    logic              short_len;
  } lpcd_stat_t;

endpackage

@@ src/lpcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpcd_ctrl
// Sequencer of the directory: accepts a request, picks the slot table
// update and the status code, and hands the response out.
// ----------------------------------------------------------------------------
module lpcd_ctrl import lpcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  lpcd_stat_t stat,
  output lpcd_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_MUL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: state_next = S_MUL;
      S_MUL:  state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // Decision table of one request, from the compare results of the datapath.
  always_comb begin
    cmd             = '0;
    cmd.op          = UPD_NONE;
    cmd.status      = ST_MISS;
    cmd.load_req    = (state == S_IDLE) && in_valid;
    cmd.load_offset = (state == S_MUL);
    if (state == S_EXEC) begin
      cmd.load_result = 1'b1;
      case (stat.func)
        FUNC_CLEAR: begin
          cmd.op     = UPD_CLEAR;
          cmd.status = ST_CLEARED;
        end
        FUNC_LOOKUP: begin
          if (stat.hit) begin
            cmd.op     = UPD_TOUCH;
            cmd.status = ST_HIT;
          end
        end
        FUNC_INSERT: begin
          if (stat.short_len) begin
            cmd.status = ST_REJECT;
          end else if (stat.hit) begin
            cmd.op     = UPD_TOUCH;
            cmd.status = ST_HIT;
          end else if (stat.free) begin
            cmd.op     = UPD_FILL;
            cmd.status = ST_FILLED;
          end else begin
            cmd.op     = UPD_EVICT;
            cmd.status = ST_EVICTED;
          end
        end
        default: begin
          cmd.status = ST_MISS;
        end
      endcase
    end
  end

endmodule

@@ src/lpcd_datapath.sv @@
// ----------------------------------------------------------------------------
// lpcd_datapath
// Slot table with parallel page compare, recency ranks, page size register
// and the response register with the byte offset product.
// ----------------------------------------------------------------------------
module lpcd_datapath import lpcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             page_bytes_we,
  input  logic [LEN_W-1:0] page_bytes_wdata,
  input  lpcd_req_t        in_req,
  input  lpcd_cmd_t        cmd,
  output lpcd_stat_t       stat,
  output lpcd_rsp_t        out_rsp
);

  logic [LEN_W-1:0]    page_bytes;
  lpcd_req_t           req_q;
  logic [SLOT_COUNT-1:0] slot_valid;
  logic [TAG_W-1:0]    slot_page    [SLOT_COUNT];
  logic [RANK_W-1:0]   slot_recency [SLOT_COUNT];
  logic [SLOT_W-1:0]   slot_q;
  logic [STATUS_W-1:0] status_q;

  logic [TAG_W-1:0]    tag;
  logic [SLOT_COUNT-1:0] match;
  logic                hit_any;
  logic                free_any;
  logic [SLOT_W-1:0]   hit_idx;
  logic [SLOT_W-1:0]   free_idx;
  logic [SLOT_W-1:0]   victim_idx;
  logic [SLOT_W-1:0]   sel_slot;
  logic [RANK_W-1:0]   sel_rank;
  logic [CNT_W-1:0]    n_valid;
  logic [PROD_W-1:0]   prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes <= PAGE_BYTES_RESET;
    end else if (page_bytes_we) begin
      page_bytes <= page_bytes_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= in_req;
    end
  end

  assign tag = req_q.page_number[TAG_W-1:0];

  // Every slot compares at once; the lowest index wins each search.
  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      match[i] = slot_valid[i] && (slot_page[i] == tag);
      if (match[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        free_idx = SLOT_W'(i);
      end
      if (slot_recency[i] == '0) begin
        victim_idx = SLOT_W'(i);
      end
    end
  end

  assign hit_any  = |match;
  assign free_any = ~&slot_valid;
  assign n_valid  = CNT_W'($countones(slot_valid));

  assign stat.func      = req_q.func;
  assign stat.hit       = hit_any;
  assign stat.free      = free_any;
  assign stat.short_len = (req_q.page_length < page_bytes);

  always_comb begin
    case (cmd.op)
      UPD_TOUCH: sel_slot = hit_idx;
      UPD_FILL:  sel_slot = free_idx;
      UPD_EVICT: sel_slot = victim_idx;
      default:   sel_slot = '0;
    endcase
  end

  assign sel_rank = slot_recency[sel_slot];

  // Valid flags and recency ranks. Touching a slot moves every newer slot
  // one rank down and puts the touched slot on top.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_recency[i] <= '0;
      end
    end else begin
      case (cmd.op)
        UPD_CLEAR: begin
          slot_valid <= '0;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_recency[i] <= '0;
          end
        end
        UPD_TOUCH, UPD_EVICT: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_valid[i] && (SLOT_W'(i) != sel_slot) && (slot_recency[i] > sel_rank)) begin
              slot_recency[i] <= slot_recency[i] - RANK_W'(1);
            end
          end
          slot_recency[sel_slot] <= RANK_W'(n_valid - CNT_W'(1));
        end
        UPD_FILL: begin
          slot_valid[sel_slot]   <= 1'b1;
          slot_recency[sel_slot] <= RANK_W'(n_valid);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.op == UPD_FILL) || (cmd.op == UPD_EVICT)) begin
      slot_page[sel_slot] <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      slot_q   <= sel_slot;
      status_q <= cmd.status;
    end
  end

  assign prod = PROD_W'(slot_q) * PROD_W'(page_bytes);

  always_ff @(posedge clk) begin
    if (cmd.load_offset) begin
      out_rsp.status      <= status_q;
      out_rsp.slot_number <= SLOT_NUM_W'(slot_q);
      out_rsp.byte_offset <= OFFSET_W'(prod);
    end
  end

endmodule

@@ src/lru_page_cache_directory.sv @@
// ----------------------------------------------------------------------------
// lru_page_cache_directory
// Directory of a fully associative page cache with least-recently-used
// replacement: lookup, insert and clear requests over a small slot table.
// ----------------------------------------------------------------------------
//
//   Channel  | Signals                               | Moves
//   ---------+---------------------------------------+---------------------
//   request  | in_valid, in_stall, in_req            | func, page, length
//   response | out_valid, out_stall, out_rsp         | status, slot, offset
//   config   | page_bytes_we, page_bytes_wdata       | page size in bytes
//
// A request is accepted in the idle state, gets the parallel page compare and
// the slot table update in the exec state, the slot times page size product
// in the mul state, and is shown as the response in the out state until taken.
// The directory holds one request at a time, so in_stall stays high from the
// cycle after acceptance until the response has been taken.
// A stalled response holds its value in the output register.
// Synchronous reset empties every slot and sets the page size to 4096.
//
module lru_page_cache_directory import lpcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lpcd_req_t        in_req,
  output logic             out_valid,
  input  logic             out_stall,
  output lpcd_rsp_t        out_rsp,
  input  logic             page_bytes_we,
  input  logic [LEN_W-1:0] page_bytes_wdata
);

  // The controller sees only the operation code and the compare results and
  // answers with the table update and the status code for the request in flight.
  lpcd_cmd_t  cmd;
  lpcd_stat_t stat;

  lpcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath keeps the slot table, the page size and the response.
  lpcd_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .page_bytes_we    (page_bytes_we),
    .page_bytes_wdata (page_bytes_wdata),
    .in_req           (in_req),
    .cmd              (cmd),
    .stat             (stat),
    .out_rsp          (out_rsp)
  );

endmodule

@@ src/lpcd_checker.sv @@
// ----------------------------------------------------------------------------
// lpcd_checker
// Port level checks of the LRU page cache directory, bound to the top level.
// ----------------------------------------------------------------------------
module lpcd_checker import lpcd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input lpcd_rsp_t        out_rsp
);

  // A stalled response keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("response changed while stalled");

  // Only one request is in flight, so a pending response blocks requests.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request channel open while a response is pending");

  // Every accepted request shows its response once the exec and mul states have passed.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> ##3 out_valid)
    else $error("response did not appear three cycles after the request");

  // Miss, reject and clear name no slot.
  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_rsp.status == ST_MISS || out_rsp.status == ST_REJECT ||
                  out_rsp.status == ST_CLEARED)
    |-> out_rsp.slot_number == '0 && out_rsp.byte_offset == '0)
    else $error("slot or offset set on a response without a slot");

  // Reset leaves no response pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("response pending after reset");

endmodule

bind lru_page_cache_directory lpcd_checker u_lpcd_checker (.*);

@@ bench/lru_page_cache_directory_test.sv @@
// ----------------------------------------------------------------------------
// lru_page_cache_directory_test
// Self-checking bench for the LRU page cache directory. A directed pass walks
// every operation, the length check at its edges, a full table with eviction
// and the unused operation code. Random traffic over a small pool of pages
// then runs under several page sizes, zero and the extremes among them. Every
// response is compared field by field against a model of the slot table that
// is updated as each request is accepted.
// ----------------------------------------------------------------------------
module lru_page_cache_directory_test;
  import lpcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The fourth operation code has no name in the package; the block answers
  // it as a miss and leaves the table alone.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Cycles to let pass once the last response is in, before a register write
  // and before the final verdict.
  localparam int SETTLE_CYCLES = 8;

  // Generous bound on the whole run. About 1240 requests, plus random sender
  // gaps and receiver stalls, stay far below this.
  localparam int CYCLE_LIMIT = 200_000;

  localparam int POOL_SIZE = 12;
  localparam int IDLE_PCT  = 37;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  lpcd_req_t        in_req = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  lpcd_rsp_t        out_rsp;
  logic             page_bytes_we = 1'b0;
  logic [LEN_W-1:0] page_bytes_wdata = '0;

  // When set, neither side idles: a long stretch at full rate.
  bit calm = 1'b0;

  int          fail_count = 0;
  int unsigned cycle_count = 0;

  // Model of the slot table and of the page size register.
  logic [SLOT_COUNT-1:0] slot_used = '0;
  logic [TAG_W-1:0]      slot_tag [SLOT_COUNT];
  int unsigned           slot_rank [SLOT_COUNT];
  logic [LEN_W-1:0]      model_page_bytes = PAGE_BYTES_RESET;

  // Responses owed by the block, oldest first.
  lpcd_rsp_t rsp_owed_q[$];
  lpcd_rsp_t rsp_want;

  lru_page_cache_directory dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req           (in_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rsp          (out_rsp),
    .page_bytes_we    (page_bytes_we),
    .page_bytes_wdata (page_bytes_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The run ends here if the responses stop coming.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model of the directory.
  // ---------------------------------------------------------------------------

  function automatic lpcd_rsp_t make_rsp(input logic [STATUS_W-1:0] st,
                                         input int unsigned slot);
    lpcd_rsp_t   r;
    int unsigned prod;
    prod          = slot * model_page_bytes;
    r.status      = st;
    r.slot_number = SLOT_NUM_W'(slot);
    r.byte_offset = OFFSET_W'(prod);
    return r;
  endfunction

  // Make a valid slot the most recent one. Ranks above its old rank move
  // down by one, so the ranks of the valid slots stay 0 .. count-1.
  function automatic void touch_slot(input int s);
    int unsigned r;
    r = slot_rank[s];
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_used[i] && i != s && slot_rank[i] > r) begin
        slot_rank[i]--;
      end
    end
    slot_rank[s] = $countones(slot_used) - 1;
  endfunction

  // Apply one accepted request to the table and queue the response it owes.
  function automatic void predict_directory(input lpcd_req_t req);
    int hit;
    int free;
    int victim;
    hit    = -1;
    free   = -1;
    victim = 0;
    if (req.func == FUNC_CLEAR) begin
      slot_used = '0;
      foreach (slot_rank[i]) slot_rank[i] = 0;
      rsp_owed_q.push_back(make_rsp(ST_CLEARED, 0));
      return;
    end
    if (req.func == FUNC_UNUSED) begin
      rsp_owed_q.push_back(make_rsp(ST_MISS, 0));
      return;
    end
    // Only valid slots take part in the compare; the first match wins.
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_tag[i] == TAG_W'(req.page_number)) hit = i;
      if (!slot_used[i]) free = i;
    end
    if (req.func == FUNC_LOOKUP) begin
      if (hit < 0) begin
        rsp_owed_q.push_back(make_rsp(ST_MISS, 0));
      end else begin
        touch_slot(hit);
        rsp_owed_q.push_back(make_rsp(ST_HIT, hit));
      end
      return;
    end
    // Insert: a short page is refused before anything else is looked at.
    if (req.page_length < model_page_bytes) begin
      rsp_owed_q.push_back(make_rsp(ST_REJECT, 0));
    end else if (hit >= 0) begin
      touch_slot(hit);
      rsp_owed_q.push_back(make_rsp(ST_HIT, hit));
    end else if (free >= 0) begin
      slot_rank[free] = $countones(slot_used);
      slot_used[free] = 1'b1;
      slot_tag[free]  = TAG_W'(req.page_number);
      rsp_owed_q.push_back(make_rsp(ST_FILLED, free));
    end else begin
      for (int i = 1; i < SLOT_COUNT; i++) begin
        if (slot_rank[i] < slot_rank[victim]) victim = i;
      end
      slot_tag[victim] = TAG_W'(req.page_number);
      touch_slot(victim);
      rsp_owed_q.push_back(make_rsp(ST_EVICTED, victim));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: random stalls and the field by field compare.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (rsp_owed_q.size() == 0) begin
        $error("response with no request outstanding: status %0d slot %0d offset %0d",
               out_rsp.status, out_rsp.slot_number, out_rsp.byte_offset);
        fail_count++;
      end else begin
        rsp_want = rsp_owed_q.pop_front();
        if (out_rsp.status !== rsp_want.status) begin
          $error("status: expected %0d, got %0d", rsp_want.status, out_rsp.status);
          fail_count++;
        end
        if (out_rsp.slot_number !== rsp_want.slot_number) begin
          $error("slot_number: expected %0d, got %0d",
                 rsp_want.slot_number, out_rsp.slot_number);
          fail_count++;
        end
        if (out_rsp.byte_offset !== rsp_want.byte_offset) begin
          $error("byte_offset: expected %0d, got %0d",
                 rsp_want.byte_offset, out_rsp.byte_offset);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------

  function automatic lpcd_req_t make_req(input logic [FUNC_W-1:0] func,
                                         input logic [PAGE_IN_W-1:0] page,
                                         input logic [LEN_W-1:0] len);
    lpcd_req_t r;
    r.func        = func;
    r.page_number = page;
    r.page_length = len;
    return r;
  endfunction

  // Offer one request and return once it has been accepted. Valid is left
  // high so that back to back requests need no second assignment in one
  // step; the drain, or an idle gap in the next call, lowers it.
  task automatic send_request(input lpcd_req_t req);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_directory(req);
  endtask

  // Stop offering requests and wait until every owed response is in.
  task automatic drain_responses();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rsp_owed_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The register is only written while the directory is idle.
  task automatic write_page_bytes(input logic [LEN_W-1:0] size);
    drain_responses();
    page_bytes_we    <= 1'b1;
    page_bytes_wdata <= size;
    @(negedge clk);
    page_bytes_we <= 1'b0;
    model_page_bytes = size;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Every operation at the reset page size: the length check on both sides
  // of its edge, the extreme page numbers, a full table, a hit that updates
  // an existing slot, eviction of the least recent slot, the unused code and
  // a clear.
  task automatic test_directed_ops();
    send_request(make_req(FUNC_LOOKUP, 32'h0, 16'h0));
    send_request(make_req(FUNC_INSERT, 32'h0, 16'd4095));
    send_request(make_req(FUNC_INSERT, 32'h0, 16'd4096));
    send_request(make_req(FUNC_INSERT, 32'hFFFF_FFFF, 16'hFFFF));
    for (int i = 0; i < 6; i++) begin
      send_request(make_req(FUNC_INSERT, 32'h100 + i, 16'd4096));
    end
    send_request(make_req(FUNC_LOOKUP, 32'h0, 16'hFFFF));
    send_request(make_req(FUNC_INSERT, 32'hFFFF_FFFF, 16'd5000));
    // The table is full; the slot holding page 0x100 is now the least recent.
    send_request(make_req(FUNC_INSERT, 32'h200, 16'd4096));
    send_request(make_req(FUNC_LOOKUP, 32'h100, 16'h0));
    send_request(make_req(FUNC_INSERT, 32'h201, 16'd4096));
    send_request(make_req(FUNC_UNUSED, 32'h0, 16'h0));
    send_request(make_req(FUNC_UNUSED, 32'hFFFF_FFFF, 16'hFFFF));
    send_request(make_req(FUNC_LOOKUP, 32'h200, 16'h0));
    send_request(make_req(FUNC_CLEAR, 32'hFFFF_FFFF, 16'hFFFF));
    send_request(make_req(FUNC_LOOKUP, 32'h0, 16'h0));
    send_request(make_req(FUNC_INSERT, 32'h300, 16'h0));
  endtask

  // Page size at its largest, at zero (every insert accepted, every offset
  // zero) and at one. Filling all eight slots reaches the largest offset.
  task automatic test_page_bytes_extremes();
    write_page_bytes(16'hFFFF);
    send_request(make_req(FUNC_CLEAR, 32'h0, 16'h0));
    send_request(make_req(FUNC_INSERT, 32'h55, 16'hFFFE));
    for (int i = 0; i < SLOT_COUNT; i++) begin
      send_request(make_req(FUNC_INSERT, 32'hA000 + i, 16'hFFFF));
    end
    send_request(make_req(FUNC_LOOKUP, 32'hA007, 16'h0));

    write_page_bytes(16'h0);
    send_request(make_req(FUNC_INSERT, 32'hA003, 16'h0));
    send_request(make_req(FUNC_INSERT, 32'hB000, 16'h0));
    send_request(make_req(FUNC_LOOKUP, 32'hB000, 16'h0));

    write_page_bytes(16'h1);
    send_request(make_req(FUNC_INSERT, 32'hC000, 16'h0));
    send_request(make_req(FUNC_INSERT, 32'hC000, 16'h1));
    send_request(make_req(FUNC_LOOKUP, 32'hC000, 16'h0));
  endtask

  // One phase of random traffic at one page size. Most requests use a small
  // pool of pages so that hits, fills and evictions all occur; the rest use
  // arbitrary page numbers. Lengths are drawn on their own.
  task automatic run_random_phase(input logic [LEN_W-1:0] size, input int count,
                                  input bit quiet);
    logic [PAGE_IN_W-1:0] pool [POOL_SIZE];
    logic [FUNC_W-1:0]    func;
    logic [PAGE_IN_W-1:0] page;
    logic [LEN_W-1:0]     len;
    int unsigned          pick;
    write_page_bytes(size);
    foreach (pool[i]) pool[i] = $urandom;
    calm = quiet;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 44) func = FUNC_LOOKUP;
      else if (pick < 92) func = FUNC_INSERT;
      else if (pick < 96) func = FUNC_CLEAR;
      else func = FUNC_UNUSED;
      if ($urandom_range(99) < 85) page = pool[$urandom_range(POOL_SIZE - 1)];
      else page = $urandom;
      pick = $urandom_range(99);
      if (pick < 60) len = LEN_W'($urandom_range(65535, model_page_bytes));
      else if (pick < 85 && model_page_bytes != 0)
        len = LEN_W'($urandom_range(model_page_bytes - 1, 0));
      else len = LEN_W'($urandom);
      send_request(make_req(func, page, len));
    end
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(16'd4096, 170, 1'b0);
    run_random_phase(16'd512, 170, 1'b0);
    run_random_phase(16'hFFFF, 170, 1'b1);
    run_random_phase(16'd1, 170, 1'b0);
    run_random_phase(16'd0, 170, 1'b0);
    run_random_phase(LEN_W'($urandom_range(65535, 1)), 170, 1'b0);
    run_random_phase(16'd4096, 180, 1'b0);
  endtask

  initial begin
    foreach (slot_tag[i]) slot_tag[i] = '0;
    foreach (slot_rank[i]) slot_rank[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_page_bytes_extremes();
    test_random_traffic();

    drain_responses();
    if (fail_count == 0 && rsp_owed_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/lpcd_pkg.sv
src/lpcd_ctrl.sv
src/lpcd_datapath.sv
src/lru_page_cache_directory.sv
src/lpcd_checker.sv
bench/lru_page_cache_directory_test.sv
